// ----- sv/kcst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcst_pkg
// Shared types and constants of the keyed context slot table: field widths,
// default sizes, command and status codes.
// ----------------------------------------------------------------------------
package kcst_pkg;

  // default table size and counter width
  localparam int SlotsDef      = 16;
  localparam int CountWidthDef = 32;

  // fixed command, key and result field widths
  localparam int CmdW   = 3;
  localparam int KeyW   = 32;
  localparam int StatW  = 2;
  localparam int IdxOutW = 4;
  localparam int OccOutW = 5;
  localparam int CntOutW = 32;

  // command codes
  typedef enum logic [CmdW-1:0] {
    CMD_REGISTER   = 3'd0,
    CMD_UNREGISTER = 3'd1,
    CMD_LOOKUP     = 3'd2,
    CMD_INC_BUFFER = 3'd3,
    CMD_INC_SPACE  = 3'd4,
    CMD_INC_QUEUE  = 3'd5,
    CMD_INC_FENCE  = 3'd6
  } cmd_t;

  // result status codes
  typedef enum logic [StatW-1:0] {
    ST_OK          = 2'd0,
    ST_INVALID_KEY = 2'd1,
    ST_TABLE_FULL  = 2'd2,
    ST_NOT_FOUND   = 2'd3
  } status_t;

endpackage

// ----- sv/keyed_context_slot_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_context_slot_table_top
// Associative slot table: register takes the lowest free slot, the other
// commands act on the lowest valid slot whose owner key matches.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   in      | in        | in_valid / in_ready  | command, owner_key
//   out     | out       | out_valid / out_ready| status, slot_index,
//           |           |                      | occupied_count, four counters
//
// One item is taken every cycle while the result register can move; its
// result passes through the input stage, then the result register.
// The key compare, the two priority encoders and one counter increment sit
// between the input stage and the result register; the table is updated on
// the same edge, so the next item always sees the new state.
// Reset clears the valid bits, the occupancy count and the two handshake
// valid flags only; no sweep. A stalled result holds the input stage, which
// takes a new item only once the result register can move.
// ----------------------------------------------------------------------------
module keyed_context_slot_table_top
  import kcst_pkg::*;
#(
  parameter int SLOTS       = SlotsDef,
  parameter int COUNT_WIDTH = CountWidthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CmdW-1:0]     command,
  input  logic signed [KeyW-1:0] owner_key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [StatW-1:0]    status,
  output logic [IdxOutW-1:0]  slot_index,
  output logic [OccOutW-1:0]  occupied_count,
  output logic [CntOutW-1:0]  buffer_count,
  output logic [CntOutW-1:0]  space_count,
  output logic [CntOutW-1:0]  queue_total,
  output logic [CntOutW-1:0]  fence_total
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OW = $clog2(SLOTS + 1);
  localparam int CW = COUNT_WIDTH;

  // input stage
  logic            stage_valid;
  logic [CmdW-1:0] cmd_q;
  logic [KeyW-1:0] key_q;

  // slot table
  logic [SLOTS-1:0] slot_valid;
  logic [KeyW-1:0]  slot_key     [SLOTS];
  logic [CW-1:0]    slot_buffers [SLOTS];
  logic [CW-1:0]    slot_spaces  [SLOTS];
  logic [CW-1:0]    slot_queues  [SLOTS];
  logic [CW-1:0]    slot_fences  [SLOTS];
  logic [OW-1:0]    occupied;
  logic [OW-1:0]    occupied_next;

  // handshake
  logic advance;
  logic fire;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;
  assign fire     = stage_valid && advance;

  // input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q <= command;
      key_q <= owner_key;
    end
  end

  // lowest matching valid slot and lowest free slot
  logic          hit_found;
  logic [IW-1:0] hit_idx;
  logic          free_found;
  logic [IW-1:0] free_idx;

  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && (slot_key[i] == key_q)) begin
        hit_found = 1'b1;
        hit_idx   = IW'(i);
      end
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // counters of the matched slot
  logic [CW-1:0] sel_buf;
  logic [CW-1:0] sel_spc;
  logic [CW-1:0] sel_que;
  logic [CW-1:0] sel_fen;

  assign sel_buf = slot_buffers[hit_idx];
  assign sel_spc = slot_spaces[hit_idx];
  assign sel_que = slot_queues[hit_idx];
  assign sel_fen = slot_fences[hit_idx];

  // command decode and table update
  status_t       res_status;
  logic [IW-1:0] res_idx;
  logic [CW-1:0] res_buf;
  logic [CW-1:0] res_spc;
  logic [CW-1:0] res_que;
  logic [CW-1:0] res_fen;
  logic          wr_cnt;
  logic          set_valid;
  logic          clr_valid;
  logic [IW-1:0] wr_idx;

  always_comb begin
    res_status    = ST_OK;
    res_idx       = '0;
    res_buf       = '0;
    res_spc       = '0;
    res_que       = '0;
    res_fen       = '0;
    wr_cnt        = 1'b0;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    wr_idx        = hit_idx;
    occupied_next = occupied;
    unique case (cmd_q)
      CMD_REGISTER: begin
        if (key_q[KeyW-1] || (key_q == '0)) begin
          res_status = ST_INVALID_KEY;
        end else if (!free_found) begin
          res_status = ST_TABLE_FULL;
        end else begin
          res_idx       = free_idx;
          wr_idx        = free_idx;
          wr_cnt        = 1'b1;
          set_valid     = 1'b1;
          occupied_next = occupied + OW'(1);
        end
      end
      CMD_UNREGISTER: begin
        if (!hit_found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_idx       = hit_idx;
          clr_valid     = 1'b1;
          occupied_next = occupied - OW'(1);
        end
      end
      CMD_LOOKUP, CMD_INC_BUFFER, CMD_INC_SPACE, CMD_INC_QUEUE, CMD_INC_FENCE: begin
        if (!hit_found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          res_idx = hit_idx;
          res_buf = sel_buf + ((cmd_q == CMD_INC_BUFFER) ? CW'(1) : CW'(0));
          res_spc = sel_spc + ((cmd_q == CMD_INC_SPACE)  ? CW'(1) : CW'(0));
          res_que = sel_que + ((cmd_q == CMD_INC_QUEUE)  ? CW'(1) : CW'(0));
          res_fen = sel_fen + ((cmd_q == CMD_INC_FENCE)  ? CW'(1) : CW'(0));
          wr_cnt  = (cmd_q != CMD_LOOKUP);
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  // slot valid bits and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      occupied   <= '0;
    end else if (fire) begin
      occupied <= occupied_next;
      if (set_valid) begin
        slot_valid[wr_idx] <= 1'b1;
      end else if (clr_valid) begin
        slot_valid[wr_idx] <= 1'b0;
      end
    end
  end

  // slot keys and counters; the old contents of a free slot are never used
  always_ff @(posedge clk) begin
    if (fire) begin
      if (set_valid) begin
        slot_key[wr_idx] <= key_q;
      end
      if (wr_cnt) begin
        slot_buffers[wr_idx] <= res_buf;
        slot_spaces[wr_idx]  <= res_spc;
        slot_queues[wr_idx]  <= res_que;
        slot_fences[wr_idx]  <= res_fen;
      end
    end
  end

  // result fields sized to the port widths
  logic [IW+IdxOutW-1:0]  idx_ext;
  logic [OW+OccOutW-1:0]  occ_ext;
  logic [CW+CntOutW-1:0]  buf_ext;
  logic [CW+CntOutW-1:0]  spc_ext;
  logic [CW+CntOutW-1:0]  que_ext;
  logic [CW+CntOutW-1:0]  fen_ext;

  assign idx_ext = {{IdxOutW{1'b0}}, res_idx};
  assign occ_ext = {{OccOutW{1'b0}}, occupied_next};
  assign buf_ext = {{CntOutW{1'b0}}, res_buf};
  assign spc_ext = {{CntOutW{1'b0}}, res_spc};
  assign que_ext = {{CntOutW{1'b0}}, res_que};
  assign fen_ext = {{CntOutW{1'b0}}, res_fen};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status         <= res_status;
      slot_index     <= idx_ext[IdxOutW-1:0];
      occupied_count <= occ_ext[OccOutW-1:0];
      buffer_count   <= buf_ext[CntOutW-1:0];
      space_count    <= spc_ext[CntOutW-1:0];
      queue_total    <= que_ext[CntOutW-1:0];
      fence_total    <= fen_ext[CntOutW-1:0];
    end
  end

endmodule
